/* rtl/bpe_pkg.sv */
// Shared types, constants and helper functions of the Bezier point evaluator.
package bpe_pkg;

   localparam int MAX_POINTS_DEF = 16;
   localparam int MAX_POINTS_LIM = 16;

   localparam int COORD_W  = 32;
   localparam int T_W      = 17;
   localparam int KIND_W   = 2;
   localparam int STATUS_W = 3;
   localparam int MUL_W    = 33;
   localparam int PROD_W   = 2 * MUL_W;
   localparam int ACC_W    = 64;
   localparam int WEIGHT_W = 32;

   localparam int BINOM_W     = 13;
   localparam int BINOM_IDX_W = 4;

   localparam int REQ_DATA_W = ((3 * COORD_W + T_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((3 * COORD_W + 7) / 8) * 8;

   localparam logic [T_W-1:0] Q_ONE = T_W'(65536);

   localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
   localparam logic [KIND_W-1:0] KIND_EVAL   = 2'd1;
   localparam int                KIND_CLEAR_BIT = 1;

   localparam logic [STATUS_W-1:0] ST_EVALUATED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_STORED    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
   localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

   typedef struct packed {
      logic signed [COORD_W-1:0] z;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] x;
   } point_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      point_type         pt;
      logic [T_W-1:0]    t;
   } req_item_type;

   typedef struct packed {
      point_type           pt;
      logic [STATUS_W-1:0] status;
   } rsp_item_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CMD,
      S_PRE,
      S_AB,
      S_W,
      S_TP,
      S_X,
      S_Y,
      S_Z,
      S_LAST,
      S_OUT
   } bpe_state_type;

   typedef logic [MAX_POINTS_LIM-1:0][MAX_POINTS_LIM-1:0][BINOM_W-1:0] binom_tab_type;

   // Pascal triangle, rows 0..15
   function automatic binom_tab_type make_binom();
      binom_tab_type tab;
      tab = '0;
      for (int r = 0; r < MAX_POINTS_LIM; r++) begin
         tab[r][0] = BINOM_W'(1);
         for (int c = 1; c <= r; c++) begin
            tab[r][c] = tab[r-1][c-1] + ((c < r) ? tab[r-1][c] : BINOM_W'(0));
         end
      end
      return tab;
   endfunction

   localparam binom_tab_type BINOM_TAB = make_binom();

   function automatic logic signed [MUL_W-1:0] zext_op(input logic [WEIGHT_W-1:0] v);
      return $signed({1'b0, v});
   endfunction

   function automatic logic signed [MUL_W-1:0] sext_op(input logic signed [COORD_W-1:0] v);
      return $signed({v[COORD_W-1], v});
   endfunction

   // Floor to Q16.16 and clamp to the signed 32-bit range.
   function automatic logic signed [COORD_W-1:0] sat_q16(input logic signed [ACC_W-1:0] acc);
      logic signed [ACC_W-17:0] q;
      q = acc[ACC_W-1:16];
      if (q > $signed((ACC_W-16)'(64'h7FFF_FFFF))) begin
         return 32'sh7FFF_FFFF;
      end else if (q < -$signed((ACC_W-16)'(64'h8000_0000))) begin
         return 32'sh8000_0000;
      end else begin
         return q[COORD_W-1:0];
      end
   endfunction

endpackage

/* rtl/bpe_mul.sv */
// Shared signed 33x33 multiplier with a registered product.
module bpe_mul (
   input  logic                              clock,
   input  logic signed [bpe_pkg::MUL_W-1:0]  op_a,
   input  logic signed [bpe_pkg::MUL_W-1:0]  op_b,
   output logic signed [bpe_pkg::PROD_W-1:0] prod
);
   import bpe_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;
endmodule

/* rtl/bpe_store.sv */
// Control point store: one write port, one registered read port.
module bpe_store #(
   parameter int MAX_POINTS = bpe_pkg::MAX_POINTS_DEF,
   parameter int IDX_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [IDX_W-1:0]    wr_addr,
   input  bpe_pkg::point_type  wr_data,
   input  logic [IDX_W-1:0]    rd_addr,
   output bpe_pkg::point_type  rd_data
);
   import bpe_pkg::*;

   point_type mem_ff [MAX_POINTS];
   point_type rd_data_ff;

   // the point index holds from S_AB through S_Z, so the data lands in time for S_X
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* rtl/bpe_ctrl.sv */
// Sequencer: point count, power table, weights and accumulators.
module bpe_ctrl #(
   parameter int MAX_POINTS = bpe_pkg::MAX_POINTS_DEF,
   parameter int IDX_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
   parameter int CNT_W      = $clog2(MAX_POINTS + 1)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                item_valid,
   output logic                                item_ready,
   input  bpe_pkg::req_item_type               item,
   output logic                                res_valid,
   input  logic                                res_take,
   output bpe_pkg::rsp_item_type               res,
   output logic signed [bpe_pkg::MUL_W-1:0]    mul_a,
   output logic signed [bpe_pkg::MUL_W-1:0]    mul_b,
   input  logic signed [bpe_pkg::PROD_W-1:0]   mul_prod,
   output logic                                st_wr_en,
   output logic [IDX_W-1:0]                    st_wr_addr,
   output bpe_pkg::point_type                  st_wr_data,
   output logic [IDX_W-1:0]                    st_rd_addr,
   input  bpe_pkg::point_type                  st_rd_data
);
   import bpe_pkg::*;

   bpe_state_type state_ff, state_in;

   logic [KIND_W-1:0]        kind_ff;
   point_type                pt_ff;
   logic [T_W-1:0]           t_ff;
   logic [T_W-1:0]           u_val;
   logic [CNT_W-1:0]         cnt_ff;
   logic [IDX_W-1:0]         i_ff;
   logic [IDX_W-1:0]         k_ff;
   logic [IDX_W-1:0]         nm1;
   logic [T_W-1:0]           pow_u_ff [MAX_POINTS];
   logic [T_W-1:0]           tp_ff;
   logic [WEIGHT_W-1:0]      w_ff;
   logic signed [ACC_W-1:0]  acc_x_ff, acc_y_ff, acc_z_ff;
   logic [STATUS_W-1:0]      status_ff;
   logic [T_W-1:0]           prod_hi;
   logic signed [ACC_W-1:0]  prod_acc;
   logic [BINOM_W-1:0]       binom;
   logic                     accept;
   logic                     is_clear, is_append, is_full, is_empty;

   assign accept    = item_valid && item_ready;
   assign u_val     = Q_ONE - t_ff;
   assign nm1       = IDX_W'(cnt_ff - CNT_W'(1));
   assign prod_hi   = mul_prod[T_W+15:16];
   assign prod_acc  = mul_prod[ACC_W-1:0];
   assign binom     = BINOM_TAB[BINOM_IDX_W'(nm1)][BINOM_IDX_W'(i_ff)];
   assign is_clear  = kind_ff[KIND_CLEAR_BIT];
   assign is_append = (kind_ff == KIND_APPEND);
   assign is_full   = (cnt_ff == CNT_W'(MAX_POINTS));
   assign is_empty  = (cnt_ff == '0);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_CMD;
         end
         S_CMD: begin
            if (is_clear || is_append || is_empty) begin
               state_in = S_OUT;
            end else if (cnt_ff == CNT_W'(1)) begin
               state_in = S_AB;
            end else begin
               state_in = S_PRE;
            end
         end
         S_PRE: begin
            if (k_ff == nm1) state_in = S_AB;
         end
         S_AB:   state_in = S_W;
         S_W:    state_in = S_TP;
         S_TP:   state_in = S_X;
         S_X:    state_in = S_Y;
         S_Y:    state_in = S_Z;
         S_Z: begin
            state_in = (i_ff == nm1) ? S_LAST : S_AB;
         end
         S_LAST: state_in = S_OUT;
         S_OUT: begin
            if (res_take) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs and multiplier operand select
   always_comb begin
      item_ready = (state_ff == S_IDLE);
      res_valid  = (state_ff == S_OUT);
      st_wr_en   = (state_ff == S_CMD) && !is_clear && is_append && !is_full;
      st_wr_addr = IDX_W'(cnt_ff);
      st_wr_data = pt_ff;
      st_rd_addr = i_ff;
      mul_a      = '0;
      mul_b      = '0;
      unique case (state_ff)
         S_CMD: begin
            mul_a = zext_op(WEIGHT_W'(Q_ONE));
            mul_b = zext_op(WEIGHT_W'(u_val));
         end
         S_PRE: begin
            mul_a = zext_op(WEIGHT_W'(prod_hi));
            mul_b = zext_op(WEIGHT_W'(u_val));
         end
         S_AB: begin
            mul_a = zext_op(WEIGHT_W'(pow_u_ff[nm1 - i_ff]));
            mul_b = zext_op(WEIGHT_W'(tp_ff));
         end
         S_W: begin
            mul_a = zext_op(WEIGHT_W'(binom));
            mul_b = zext_op(WEIGHT_W'(prod_hi));
         end
         S_TP: begin
            mul_a = zext_op(WEIGHT_W'(tp_ff));
            mul_b = zext_op(WEIGHT_W'(t_ff));
         end
         S_X: begin
            mul_a = zext_op(w_ff);
            mul_b = sext_op(st_rd_data.x);
         end
         S_Y: begin
            mul_a = zext_op(w_ff);
            mul_b = sext_op(st_rd_data.y);
         end
         S_Z: begin
            mul_a = zext_op(w_ff);
            mul_b = sext_op(st_rd_data.z);
         end
         S_IDLE, S_LAST, S_OUT: begin
            mul_a = '0;
            mul_b = '0;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_CMD) begin
            if (is_clear) begin
               cnt_ff <= '0;
            end else if (is_append && !is_full) begin
               cnt_ff <= cnt_ff + CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               kind_ff <= item.kind;
               pt_ff   <= item.pt;
               t_ff    <= (item.t > Q_ONE) ? Q_ONE : item.t;
            end
         end
         S_CMD: begin
            acc_x_ff    <= '0;
            acc_y_ff    <= '0;
            acc_z_ff    <= '0;
            i_ff        <= '0;
            k_ff        <= IDX_W'(1);
            tp_ff       <= Q_ONE;
            pow_u_ff[0] <= Q_ONE;
            if (is_clear) begin
               status_ff <= ST_CLEARED;
            end else if (is_append) begin
               status_ff <= is_full ? ST_FULL : ST_STORED;
            end else begin
               status_ff <= is_empty ? ST_EMPTY : ST_EVALUATED;
            end
         end
         S_PRE: begin
            pow_u_ff[k_ff] <= prod_hi;
            k_ff           <= k_ff + IDX_W'(1);
         end
         S_AB: begin
            // the z product of the previous point lands here
            if (i_ff != '0) acc_z_ff <= acc_z_ff + prod_acc;
         end
         S_TP: begin
            w_ff <= mul_prod[WEIGHT_W-1:0];
         end
         S_X: begin
            tp_ff <= prod_hi;
         end
         S_Y: begin
            acc_x_ff <= acc_x_ff + prod_acc;
         end
         S_Z: begin
            acc_y_ff <= acc_y_ff + prod_acc;
            if (i_ff != nm1) i_ff <= i_ff + IDX_W'(1);
         end
         S_LAST: begin
            acc_z_ff <= acc_z_ff + prod_acc;
         end
         S_W, S_OUT: begin
         end
         default: begin
         end
      endcase
   end

   assign res.pt.x   = sat_q16(acc_x_ff);
   assign res.pt.y   = sat_q16(acc_y_ff);
   assign res.pt.z   = sat_q16(acc_z_ff);
   assign res.status = status_ff;
endmodule

/* rtl/bezier_point_evaluation.sv */
// Top level of the Bezier point evaluator: stream ports and output register.
//
//   channel  | dir | tdata (low bit up)                        | tuser
//   ---------+-----+-------------------------------------------+-------------
//   req_     | in  | pt_x, pt_y, pt_z, param_t, zero pad (120) | kind (2)
//   rsp_     | out | curve_x, curve_y, curve_z (96)            | status (3)
//
// Append, clear and an evaluate on an empty list go from S_CMD straight to S_OUT.
// Evaluate over n points steps through S_PRE (for n above one), then S_AB, S_W, S_TP,
// S_X, S_Y and S_Z per point, and S_LAST; the single shared 33x33 multiplier serves each step.
// Reset empties the point list; stored coordinates are not cleared.
// A finished result waits in the output register while the next beat is taken.
module bezier_point_evaluation #(
   parameter int MAX_POINTS = bpe_pkg::MAX_POINTS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [bpe_pkg::REQ_DATA_W-1:0]     req_tdata,  // pt_x, pt_y, pt_z, param_t
   input  logic [bpe_pkg::KIND_W-1:0]         req_tuser,  // kind
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [bpe_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // curve_x, curve_y, curve_z
   output logic [bpe_pkg::STATUS_W-1:0]       rsp_tuser   // status
);
   import bpe_pkg::*;

   localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CNT_W = $clog2(MAX_POINTS + 1);

   req_item_type             item;
   rsp_item_type             res;
   logic                     res_valid;
   logic                     res_take;
   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] mul_prod;
   logic                     st_wr_en;
   logic [IDX_W-1:0]         st_wr_addr, st_rd_addr;
   point_type                st_wr_data, st_rd_data;

   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_item_type             rsp_item_ff;

   assign item.kind = req_tuser;
   assign item.pt.x = req_tdata[COORD_W-1:0];
   assign item.pt.y = req_tdata[2*COORD_W-1:COORD_W];
   assign item.pt.z = req_tdata[3*COORD_W-1:2*COORD_W];
   assign item.t    = req_tdata[3*COORD_W+T_W-1:3*COORD_W];

   bpe_ctrl #(
      .MAX_POINTS (MAX_POINTS),
      .IDX_W      (IDX_W),
      .CNT_W      (CNT_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .item_valid (req_tvalid),
      .item_ready (req_tready),
      .item       (item),
      .res_valid  (res_valid),
      .res_take   (res_take),
      .res        (res),
      .mul_a      (mul_a),
      .mul_b      (mul_b),
      .mul_prod   (mul_prod),
      .st_wr_en   (st_wr_en),
      .st_wr_addr (st_wr_addr),
      .st_wr_data (st_wr_data),
      .st_rd_addr (st_rd_addr),
      .st_rd_data (st_rd_data)
   );

   bpe_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (mul_prod)
   );

   bpe_store #(
      .MAX_POINTS (MAX_POINTS),
      .IDX_W      (IDX_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (st_wr_data),
      .rd_addr (st_rd_addr),
      .rd_data (st_rd_data)
   );

   // load the output register when it is empty or being drained
   assign res_take = res_valid && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_take) begin
         rsp_item_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_item_ff.pt.z, rsp_item_ff.pt.y, rsp_item_ff.pt.x};
   assign rsp_tuser  = rsp_item_ff.status;
endmodule

/* rtl/bpe_checker.sv */
// Port-level checks for the Bezier point evaluator, bound to the top level.
module bpe_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [bpe_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [bpe_pkg::STATUS_W-1:0]   rsp_tuser
);
   import bpe_pkg::*;

   // one item at a time: busy right after a beat is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken while an item is in flight");

   // results other than an evaluation carry zero coordinates
   a_zero_coords: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ST_EVALUATED) |-> (rsp_tdata == '0))
      else $error("non-evaluate result with nonzero coordinates");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser <= ST_EMPTY))
      else $error("status code out of range");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result beat changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");
endmodule

bind bezier_point_evaluation bpe_checker u_bpe_checker (.*);

/* tb/bezier_point_evaluation_test.sv */
// Self-checking stream testbench for the Bezier point evaluator.
`timescale 1ns / 1ps

module bezier_point_evaluation_test;
   import bpe_pkg::*;

   localparam logic [KIND_W-1:0] KIND_CLEAR     = 2'd2;
   localparam logic [KIND_W-1:0] KIND_CLEAR_ALT = 2'd3;
   localparam int CAPACITY     = MAX_POINTS_DEF;
   localparam int QUIET_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 150;
   localparam int DIRECTED     = 25;
   localparam int PHASE_ITEMS  = 400;
   localparam int RANDOM_ITEMS = 1200;

   // Tracks the point list and queues the expected curve point per beat.
   class curve_board;
      logic signed [COORD_W-1:0] px[CAPACITY];
      logic signed [COORD_W-1:0] py[CAPACITY];
      logic signed [COORD_W-1:0] pz[CAPACITY];
      int unsigned   count;
      rsp_item_type  pending[$];
      int            errors, appends, drops, evals, empties, clears;

      function new();
         count = 0;
         errors = 0; appends = 0; drops = 0; evals = 0; empties = 0; clears = 0;
      endfunction

      function longint unsigned q1_pow(longint unsigned base, int unsigned e);
         longint unsigned p;
         p = 65536;
         for (int k = 0; k < e; k++) p = (p * base) >> 16;
         return p;
      endfunction

      // Floor to Q16.16, then clamp to the signed 32-bit range.
      function logic signed [COORD_W-1:0] floor_sat(longint acc);
         longint q;
         q = acc >>> 16;
         if (q > 64'sh7FFF_FFFF) q = 64'sh7FFF_FFFF;
         if (q < -64'sh8000_0000) q = -64'sh8000_0000;
         return q[COORD_W-1:0];
      endfunction

      function void note_input(req_item_type r);
         rsp_item_type    e;
         longint unsigned tq, uq, a, b;
         int unsigned     ab, binom, w;
         longint          ax, ay, az;
         e = '0;
         if (r.kind[KIND_CLEAR_BIT]) begin
            count = 0;
            e.status = ST_CLEARED;
            clears++;
         end else if (r.kind == KIND_APPEND) begin
            if (count >= CAPACITY) begin
               e.status = ST_FULL;
               drops++;
            end else begin
               px[count] = r.pt.x;
               py[count] = r.pt.y;
               pz[count] = r.pt.z;
               count++;
               e.status = ST_STORED;
            end
            appends++;
         end else if (count == 0) begin
            e.status = ST_EMPTY;
            empties++;
            evals++;
         end else begin
            tq = (r.t > Q_ONE) ? 65536 : r.t;
            uq = 65536 - tq;
            ax = 0; ay = 0; az = 0;
            binom = 1;
            for (int i = 0; i < count; i++) begin
               a = q1_pow(uq, count - 1 - i);
               b = q1_pow(tq, i);
               ab = 32'((a * b) >> 16);
               w = binom * ab;
               ax += longint'(w) * longint'(px[i]);
               ay += longint'(w) * longint'(py[i]);
               az += longint'(w) * longint'(pz[i]);
               // advance along row count-1 of the binomial triangle
               binom = binom * (count - 1 - i) / (i + 1);
            end
            e.pt.x = floor_sat(ax);
            e.pt.y = floor_sat(ay);
            e.pt.z = floor_sat(az);
            e.status = ST_EVALUATED;
            evals++;
         end
         pending.push_back(e);
      endfunction

      function void check_result(logic [RSP_DATA_W-1:0] data, logic [STATUS_W-1:0] status);
         rsp_item_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result x %h y %h z %h status %0d",
                     $time, data[31:0], data[63:32], data[95:64], status);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (data[31:0] !== e.pt.x) begin
            $display("%0t: curve_x expected %h got %h", $time, e.pt.x, data[31:0]);
            errors++;
         end
         if (data[63:32] !== e.pt.y) begin
            $display("%0t: curve_y expected %h got %h", $time, e.pt.y, data[63:32]);
            errors++;
         end
         if (data[95:64] !== e.pt.z) begin
            $display("%0t: curve_z expected %h got %h", $time, e.pt.z, data[95:64]);
            errors++;
         end
         if (status !== e.status) begin
            $display("%0t: status expected %0d got %0d", $time, e.status, status);
            errors++;
         end
      endfunction
   endclass

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata;
   logic [KIND_W-1:0]       req_tuser;
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic [STATUS_W-1:0]     rsp_tuser;

   curve_board board;
   int         send_idle_pct;
   int         recv_idle_pct;
   int         beats_sent;
   int         quiet;

   bezier_point_evaluation uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #1 clock = ~clock;

   task automatic send_item(input logic [KIND_W-1:0] kind, input logic signed [31:0] x,
                            input logic signed [31:0] y, input logic signed [31:0] z,
                            input logic [T_W-1:0] t);
      req_item_type r;
      r.kind = kind;
      r.pt.x = x;
      r.pt.y = y;
      r.pt.z = z;
      r.t = t;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'({r.t, r.pt.z, r.pt.y, r.pt.x});
      req_tuser  <= r.kind;
      do @(posedge clock); while (!req_tready);
      board.note_input(r);
      beats_sent++;
   endtask

   function automatic logic signed [31:0] pick_coord();
      case ($urandom_range(7))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2: return $signed(32'($urandom_range(32'h3_FFFF))) - 32'sh2_0000;
         default: return $signed($urandom);
      endcase
   endfunction

   function automatic logic [T_W-1:0] pick_t();
      case ($urandom_range(9))
         0: return '0;
         1: return Q_ONE;
         2: return T_W'(65536 + $urandom_range(1, 65535));
         3: return T_W'($urandom_range(1, 15));
         default: return T_W'($urandom_range(0, 65536));
      endcase
   endfunction

   // Result side: random backpressure, checking and the no-progress watchdog.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         quiet <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) board.check_result(rsp_tdata, rsp_tuser);
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready)) begin
            quiet <= 0;
         end else if (quiet >= QUIET_LIMIT) begin
            $display("%0t: watchdog, no beat for %0d cycles", $time, QUIET_LIMIT);
            $display("end of test: mismatches");
            $finish;
         end else begin
            quiet <= quiet + 1;
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   initial begin
      int n_pts;
      int n_evals;
      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = KIND_APPEND;
      send_idle_pct = 9;
      recv_idle_pct = 64;
      beats_sent = 0;
      board = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // empty list, both clear encodings
      send_item(KIND_EVAL, '0, '0, '0, T_W'(32768));
      send_item(KIND_CLEAR, '1, '1, '1, '1);
      send_item(KIND_CLEAR_ALT, '0, '0, '0, '0);
      // fill the list with alternating extremes, then overflow it once
      for (int i = 0; i <= CAPACITY; i++) begin
         if (i % 2 == 0)
            send_item(KIND_APPEND, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'shFFFF_FFFF, '0);
         else
            send_item(KIND_APPEND, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0000_0000, '1);
      end
      send_item(KIND_EVAL, '0, '0, '0, '0);
      send_item(KIND_EVAL, '0, '0, '0, Q_ONE);
      send_item(KIND_EVAL, '1, '1, '1, T_W'(17'h1_FFFF));
      send_item(KIND_EVAL, '0, '0, '0, T_W'(32768));
      send_item(KIND_CLEAR, '0, '0, '0, '0);

      while (beats_sent < DIRECTED + RANDOM_ITEMS) begin
         case ((beats_sent - DIRECTED) / PHASE_ITEMS)
            0: begin
               send_idle_pct = 9;
               recv_idle_pct = 64;
            end
            1: begin
               send_idle_pct = 64;
               recv_idle_pct = 9;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         if ($urandom_range(9) == 0) begin
            send_item(KIND_W'($urandom_range(3)), $signed($urandom), $signed($urandom),
                      $signed($urandom), T_W'($urandom));
         end else begin
            send_item($urandom_range(1) ? KIND_CLEAR : KIND_CLEAR_ALT,
                      $signed($urandom), $signed($urandom), $signed($urandom), T_W'($urandom));
            case ($urandom_range(9))
               0: n_pts = 0;
               1, 2: n_pts = $urandom_range(1, CAPACITY);
               3: n_pts = $urandom_range(CAPACITY, CAPACITY + 3);
               default: n_pts = $urandom_range(1, 4);
            endcase
            for (int i = 0; i < n_pts; i++)
               send_item(KIND_APPEND, pick_coord(), pick_coord(), pick_coord(), T_W'($urandom));
            n_evals = $urandom_range(1, 4);
            for (int i = 0; i < n_evals; i++)
               send_item(KIND_EVAL, $signed($urandom), $signed($urandom), $signed($urandom),
                         pick_t());
         end
      end
      req_tvalid <= 1'b0;

      while (board.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d appends (%0d dropped on a full list), %0d evaluates",
               board.appends, board.drops, board.evals);
      $display("  (%0d on an empty list) and %0d clears over three backpressure phases",
               board.empties, board.clears);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
